// File: design/xeed_pkg.sv
// xeed_pkg: shared types, character codes and entity tables for the
// entity/escape decoder. No dependencies.
package xeed_pkg;

  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned QPTR_W    = $clog2(JOB_DEPTH);
  localparam int unsigned QCNT_W    = $clog2(JOB_DEPTH + 1);

  // character codes
  localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [UNIT_W-1:0] CH_NL     = 16'h000A;
  localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_QUOT   = 16'h0022;
  localparam logic [UNIT_W-1:0] CH_AMP    = 16'h0026;
  localparam logic [UNIT_W-1:0] CH_SLASH  = 16'h002F;
  localparam logic [UNIT_W-1:0] CH_LT     = 16'h003C;
  localparam logic [UNIT_W-1:0] CH_GT     = 16'h003E;
  localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [UNIT_W-1:0] CH_LOW_N  = 16'h006E;
  localparam logic [UNIT_W-1:0] CH_LOW_T  = 16'h0074;

  // entity codes, in match priority order
  localparam logic [1:0] ENT_LT   = 2'd0;
  localparam logic [1:0] ENT_GT   = 2'd1;
  localparam logic [1:0] ENT_AMP  = 2'd2;
  localparam logic [1:0] ENT_QUOT = 2'd3;

  // held-sequence kinds (front state)
  localparam logic [1:0] HK_NONE  = 2'd0;
  localparam logic [1:0] HK_ENT   = 2'd1;
  localparam logic [1:0] HK_SLASH = 2'd2;

  // one job: literal units of a flushed prefix, then an optional tail unit
  typedef struct packed {
    logic [LEN_W-1:0]  pre_len;
    logic              pre_slash;  // prefix is a single slash, not an entity
    logic              pre_bs;     // that slash is a backslash
    logic [1:0]        pre_ent;
    logic              tail_valid;
    logic [UNIT_W-1:0] tail_unit;
    logic              fin;
  } xeed_job_t;

  function automatic logic [UNIT_W-1:0] ent_unit(input logic [1:0] p,
                                                 input logic [LEN_W-1:0] i);
    logic [UNIT_W-1:0] u;
    u = 16'h0000;
    if (i == 3'd0) begin
      u = CH_AMP;
    end else begin
      unique case (p)
        ENT_LT: begin
          unique case (i)
            3'd1:    u = 16'h006C;
            3'd2:    u = 16'h0074;
            3'd3:    u = 16'h003B;
            default: u = 16'h0000;
          endcase
        end
        ENT_GT: begin
          unique case (i)
            3'd1:    u = 16'h0067;
            3'd2:    u = 16'h0074;
            3'd3:    u = 16'h003B;
            default: u = 16'h0000;
          endcase
        end
        ENT_AMP: begin
          unique case (i)
            3'd1:    u = 16'h0061;
            3'd2:    u = 16'h006D;
            3'd3:    u = 16'h0070;
            3'd4:    u = 16'h003B;
            default: u = 16'h0000;
          endcase
        end
        default: begin
          unique case (i)
            3'd1:    u = 16'h0071;
            3'd2:    u = 16'h0075;
            3'd3:    u = 16'h006F;
            3'd4:    u = 16'h0074;
            3'd5:    u = 16'h003B;
            default: u = 16'h0000;
          endcase
        end
      endcase
    end
    return u;
  endfunction

  function automatic logic [LEN_W-1:0] ent_len(input logic [1:0] p);
    logic [LEN_W-1:0] l;
    unique case (p)
      ENT_LT:  l = 3'd4;
      ENT_GT:  l = 3'd4;
      ENT_AMP: l = 3'd5;
      default: l = 3'd6;
    endcase
    return l;
  endfunction

  function automatic logic [UNIT_W-1:0] ent_char(input logic [1:0] p);
    logic [UNIT_W-1:0] c;
    unique case (p)
      ENT_LT:  c = CH_LT;
      ENT_GT:  c = CH_GT;
      ENT_AMP: c = CH_AMP;
      default: c = CH_QUOT;
    endcase
    return c;
  endfunction

endpackage

// File: design/xml_entity_escape_decoder.sv
// Entity and escape decoder for a UTF-16 text stream.
// The first result of an accepted item is written into the job queue and then
// expanded from it into the output register.
// Throughput: one code unit per cycle while the queue is not full (in_stall_o); an item's
// results leave the back end one at a time, absorbed by a four-job queue.
// Reset (rst_ni, async, active low) clears the held prefix, queue and output.
// Depends on xeed_pkg, xeed_front, xeed_fifo, xeed_back.
module xml_entity_escape_decoder import xeed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [UNIT_W-1:0] code_unit_i,
  input  logic              end_of_text_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [UNIT_W-1:0] out_unit_o,
  output logic              unit_valid_o,
  output logic              end_marker_o
);

  logic      q_full;
  logic      push;
  logic      pop;
  logic      job_valid;
  xeed_job_t job_in;
  xeed_job_t job_out;

  assign in_stall_o = q_full;

  xeed_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .code_unit_i   (code_unit_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (job_in)
  );

  xeed_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  xeed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_unit_o   (out_unit_o),
    .unit_valid_o (unit_valid_o),
    .end_marker_o (end_marker_o)
  );

endmodule

// File: design/xeed_front.sv
// xeed_front: accepts code units, tracks the pending entity/escape prefix
// and turns each item into at most one job. Depends on xeed_pkg.
module xeed_front import xeed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [UNIT_W-1:0] code_unit_i,
  input  logic              end_of_text_i,
  input  logic              q_full_i,
  output logic              push_o,
  output xeed_job_t         job_o
);

  logic [1:0]       kind_q, kind_d;
  logic [1:0]       pat_q, pat_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             bs_q, bs_d;

  logic             accept;
  logic             found;
  logic [1:0]       found_ent;
  logic             fresh;
  logic             drop;
  logic [UNIT_W-1:0] esc;
  logic [LEN_W-1:0] len_inc;
  xeed_job_t        job;

  assign accept  = in_valid_i && !q_full_i;
  assign len_inc = len_q + 3'd1;
  assign drop    = (code_unit_i < CH_SPACE) && (code_unit_i != CH_NL);

  // next entity character; after a lone '&' any entity may follow
  always_comb begin
    found     = 1'b0;
    found_ent = pat_q;
    if (len_q == 3'd1) begin
      for (int q = 3; q >= 0; q--) begin
        if (ent_unit(q[1:0], 3'd1) == code_unit_i) begin
          found     = 1'b1;
          found_ent = q[1:0];
        end
      end
    end else begin
      found = (ent_unit(pat_q, len_q) == code_unit_i);
    end
  end

  always_comb begin
    unique case (code_unit_i)
      CH_LOW_N: esc = CH_NL;
      CH_LOW_T: esc = CH_TAB;
      CH_QUOT:  esc = CH_QUOT;
      default:  esc = 16'h0000;
    endcase
  end

  always_comb begin
    job            = '0;
    job.tail_unit  = code_unit_i;
    job.fin        = end_of_text_i;
    kind_d         = HK_NONE;
    pat_d          = ENT_LT;
    len_d          = 3'd1;
    bs_d           = 1'b0;
    fresh          = 1'b1;

    unique case (kind_q)
      HK_ENT: begin
        if (found) begin
          fresh = 1'b0;
          if (len_inc == ent_len(found_ent)) begin
            job.tail_valid = 1'b1;
            job.tail_unit  = ent_char(found_ent);
          end else if (end_of_text_i) begin
            // incomplete at end of text: flush the whole prefix literally
            job.pre_len = len_inc;
            job.pre_ent = found_ent;
          end else begin
            kind_d = HK_ENT;
            pat_d  = found_ent;
            len_d  = len_inc;
          end
        end else begin
          job.pre_len = len_q;
          job.pre_ent = pat_q;
        end
      end
      HK_SLASH: begin
        if (esc != 16'h0000) begin
          fresh          = 1'b0;
          job.tail_valid = 1'b1;
          job.tail_unit  = esc;
        end else begin
          job.pre_len   = 3'd1;
          job.pre_slash = 1'b1;
          job.pre_bs    = bs_q;
        end
      end
      default: ;
    endcase

    // the new unit scanned from scratch
    if (fresh) begin
      if (drop) begin
        job.tail_valid = 1'b0;
      end else if (code_unit_i == CH_AMP && !end_of_text_i) begin
        kind_d = HK_ENT;
      end else if ((code_unit_i == CH_SLASH || code_unit_i == CH_BSLASH) &&
                   !end_of_text_i) begin
        kind_d = HK_SLASH;
        bs_d   = (code_unit_i == CH_BSLASH);
      end else begin
        job.tail_valid = 1'b1;
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.pre_len != 3'd0 || job.tail_valid || job.fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= HK_NONE;
      pat_q  <= ENT_LT;
      len_q  <= 3'd1;
      bs_q   <= 1'b0;
    end else if (accept) begin
      kind_q <= kind_d;
      pat_q  <= pat_d;
      len_q  <= len_d;
      bs_q   <= bs_d;
    end
  end

endmodule

// File: design/xeed_fifo.sv
// xeed_fifo: short job queue between front and back end.
// Depends on xeed_pkg.
module xeed_fifo import xeed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  xeed_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output xeed_job_t job_o
);

  xeed_job_t         mem_q [JOB_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// File: design/xeed_back.sv
// xeed_back: expands queued jobs into result items, one per cycle unless the output
// is stalled, into an output register. Depends on xeed_pkg.
module xeed_back import xeed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  xeed_job_t         job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [UNIT_W-1:0] out_unit_o,
  output logic              unit_valid_o,
  output logic              end_marker_o
);

  logic [LEN_W-1:0]  idx_q;
  logic              out_valid_q;
  logic [UNIT_W-1:0] unit_q;
  logic              uvalid_q;
  logic              end_q;

  logic [LEN_W-1:0]  total;
  logic              last;
  logic              load;
  logic              has_unit;
  logic [UNIT_W-1:0] unit;

  assign total    = job_i.pre_len + LEN_W'(job_i.tail_valid);
  assign has_unit = (total != '0);
  // a job with no units still gives one (empty end marker) item
  assign last     = ({1'b0, idx_q} + 4'd1) >= {1'b0, total};
  assign load     = job_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && last;

  always_comb begin
    if (!has_unit) begin
      unit = 16'h0000;
    end else if (idx_q < job_i.pre_len) begin
      if (job_i.pre_slash) begin
        unit = job_i.pre_bs ? CH_BSLASH : CH_SLASH;
      end else begin
        unit = ent_unit(job_i.pre_ent, idx_q);
      end
    end else begin
      unit = job_i.tail_unit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? '0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q   <= unit;
      uvalid_q <= has_unit;
      end_q    <= job_i.fin && last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_unit_o   = unit_q;
  assign unit_valid_o = uvalid_q;
  assign end_marker_o = end_q;

endmodule
